/* rtl/well_pkg.sv */
// Shared types, constants and the seed table for the WELL512a generator.
`default_nettype none

package well_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned POOL_DEPTH  = 16;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [WORD_W-1:0] SEED_VALUE  = 32'd5489;
	localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda442d24;

	// Reset values of the range registers, signed Q16.16.
	localparam logic [WORD_W-1:0] RANGE_LOW_RESET  = 32'h0000_0000;
	localparam logic [WORD_W-1:0] RANGE_HIGH_RESET = 32'h0001_0000;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 1'd1;

	typedef logic [POOL_DEPTH-1:0][WORD_W-1:0] pool_t;

	// One generated number waiting for scaling.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} item_t;

	// Scaling setup derived from the range registers.
	typedef struct packed {
		logic [WORD_W-1:0] low;
		logic [WORD_W-1:0] span_mag;
		logic              span_neg;
	} scale_cfg_t;

	// Initial pool contents from the seed recurrence, evaluated at elaboration.
	function automatic pool_t pool_seed();
		pool_t             p;
		logic [WORD_W-1:0] w;
		w    = SEED_VALUE;
		p    = '0;
		p[0] = w;
		for (int i = 1; i < POOL_DEPTH; i++) begin
			w    = SEED_MULT * (w ^ (w >> 30)) + WORD_W'(i);
			p[i] = w;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

/* rtl/well512a_random_generator_unit.sv */
// Top level of the WELL512a random generator with range scaling.
`default_nettype none

// WELL512a pseudo-random generator. Every item accepted on the input channel
// requests one number; every result item carries the generated 32-bit word,
// that word mapped into [range_low, range_high) as signed Q16.16, and a copy
// of the batch mark. The block sustains one item per clock cycle while the
// output is not stalled: the pool of sixteen words is kept as a rotating
// register so the four taps of the recurrence sit at fixed places.
// An accepted item is written into the queue; the scaling path then
// registers the queue head, then the 32x32 product of span and word,
// then the final add. A small queue between generation and scaling lets
// the input keep flowing while the output is stalled, until the queue and
// the three back-end registers fill.
// The range registers are written through the configuration channel, which
// is always ready; index 0 is range_low, index 1 is range_high. Write them
// only while no item is in flight. A reversed range is allowed and yields
// values in [range_high, range_low]; an empty range returns range_low.
// After reset the pool holds the standard seed sequence from 5489, the
// range is [0, 1.0) and no clearing pass is needed.

module well512a_random_generator_unit
	import well_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   last_request,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [WORD_W-1:0]           raw_word,
	output logic signed [WORD_W-1:0]    scaled_value,
	output logic                        last_result,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]      cfg_data
);

	logic [WORD_W-1:0] range_low_q;
	logic [WORD_W-1:0] range_high_q;
	logic [WORD_W-1:0] span_mag_q;
	logic              span_neg_q;

	logic [WORD_W:0]   span;
	logic [WORD_W:0]   span_abs;

	item_t      push_item;
	item_t      head_item;
	logic       push, pop, head_valid, queue_full;
	scale_cfg_t scale_cfg;

	// Configuration writes land directly in the range registers, so the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RESET;
			range_high_q <= RANGE_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RANGE_LOW:  range_low_q  <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The span is taken at 33 bits; its magnitude always fits in 32 bits.
	// It is registered so the multiplier sees a clean operand. An accepted
	// item passes the queue and the first scaling register before the multiplier,
	// so a write in the same cycle as the accept is still seen in time.
	assign span     = {range_high_q[WORD_W-1], range_high_q}
	                - {range_low_q[WORD_W-1], range_low_q};
	assign span_abs = span[WORD_W] ? (~span + (WORD_W+1)'(1)) : span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_mag_q <= RANGE_HIGH_RESET - RANGE_LOW_RESET;
			span_neg_q <= 1'b0;
		end else begin
			span_mag_q <= span_abs[WORD_W-1:0];
			span_neg_q <= span[WORD_W];
		end
	end

	assign scale_cfg.low      = range_low_q;
	assign scale_cfg.span_mag = span_mag_q;
	assign scale_cfg.span_neg = span_neg_q;

	well_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.last_request (last_request),
		.queue_full   (queue_full),
		.push         (push),
		.push_item    (push_item)
	);

	// The queue depth must be a power of two, at least two.
	well_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_item  (head_item),
		.head_valid (head_valid),
		.full       (queue_full)
	);

	well_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.head_valid   (head_valid),
		.pop          (pop),
		.scale_cfg    (scale_cfg),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.raw_word     (raw_word),
		.scaled_value (scaled_value),
		.last_result  (last_result)
	);

endmodule

`default_nettype wire

/* rtl/well_front.sv */
// Front end: accepts requests, runs the WELL512a recurrence on a rotating pool.
`default_nettype none

module well_front
	import well_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  last_request,
	input  wire logic  queue_full,
	output logic       push,
	output item_t      push_item
);

	localparam pool_t POOL_SEED = pool_seed();

	// pool_q[k] holds the word at (position + k) mod 16, so every tap is fixed.
	pool_t pool_q;

	logic [WORD_W-1:0] a, c9, c13, e;
	logic [WORD_W-1:0] b, c, n0, d, n1;

	always_comb begin
		a   = pool_q[0];
		c9  = pool_q[9];
		c13 = pool_q[13];
		e   = pool_q[15];
		b   = a ^ (a << 16) ^ c13 ^ (c13 << 15);
		c   = c9 ^ (c9 >> 11);
		n0  = b ^ c;
		d   = n0 ^ ((n0 << 5) & TEMPER_MASK);
		n1  = e ^ (e << 2) ^ b ^ (b << 18) ^ (c << 28) ^ d;
	end

	assign in_ready       = ~queue_full;
	assign push           = in_valid & in_ready;
	assign push_item.word = n1;
	assign push_item.last = last_request;

	// The position steps back by one: the new word at the old position-1
	// lands at slot 0, the word written at the old position at slot 1, and
	// the rest shift up by one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_SEED;
		end else if (push) begin
			pool_q[0] <= n1;
			pool_q[1] <= n0;
			for (int k = 2; k < POOL_DEPTH; k++) begin
				pool_q[k] <= pool_q[k-1];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/well_queue.sv */
// Small FIFO that decouples number generation from scaling.
`default_nettype none

module well_queue
	import well_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head_item,
	output logic       head_valid,
	output logic       full
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head_item  = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers wrap on their own since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/well_back.sv */
// Back end: scales each word into the configured range and holds the result.
`default_nettype none

module well_back
	import well_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire item_t        head_item,
	input  wire logic         head_valid,
	output logic              pop,
	input  wire scale_cfg_t   scale_cfg,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [WORD_W-1:0] raw_word,
	output logic signed [WORD_W-1:0] scaled_value,
	output logic              last_result
);

	logic                valid_s1, valid_s2, out_valid_q;
	logic [WORD_W-1:0]   word_s1, word_s2;
	logic                last_s1, last_s2;
	logic [2*WORD_W-1:0] prod_s2;
	logic [WORD_W-1:0]   raw_q, scaled_q;
	logic                last_q;

	logic en1, en2, en3;
	logic [WORD_W-1:0] hi;
	logic              nz;

	assign en3 = ~out_valid_q | out_ready;
	assign en2 = ~valid_s2 | en3;
	assign en1 = ~valid_s1 | en2;
	assign pop = head_valid & en1;

	// Upper product word, and whether anything was lost below it; a negative
	// span rounds the quotient toward minus infinity.
	assign hi = prod_s2[2*WORD_W-1:WORD_W];
	assign nz = (prod_s2[WORD_W-1:0] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pop;
			if (en2) valid_s2 <= valid_s1;
			if (en3) out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			word_s1 <= head_item.word;
			last_s1 <= head_item.last;
		end
		if (en2) begin
			word_s2 <= word_s1;
			last_s2 <= last_s1;
			prod_s2 <= {{WORD_W{1'b0}}, scale_cfg.span_mag} * {{WORD_W{1'b0}}, word_s1};
		end
		if (en3) begin
			raw_q  <= word_s2;
			last_q <= last_s2;
			if (scale_cfg.span_neg) begin
				scaled_q <= scale_cfg.low - hi - WORD_W'(nz);
			end else begin
				scaled_q <= scale_cfg.low + hi;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign raw_word     = raw_q;
	assign scaled_value = scaled_q;
	assign last_result  = last_q;

endmodule

`default_nettype wire
